/* src/rau_pkg.sv */
package rau_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned DEN_W   = 31;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned FUNC_W  = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_MUL  = 3'd2,
        FN_DIV  = 3'd3,
        FN_NEG  = 3'd4,
        FN_RECIP = 3'd5,
        FN_NORM = 3'd6,
        FN_RSVD = 3'd7
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FIELD_W-1:0] a_num;
        logic [FIELD_W-1:0] a_den;
        logic [FIELD_W-1:0] b_num;
        logic [FIELD_W-1:0] b_den;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] res_num;
        logic [DEN_W-1:0]   res_den;
        logic [STAT_W-1:0]  status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_CHECK,
        S_OUT
    } t_state;

endpackage

/* src/rau_if.sv */
interface rau_req_if;
    import rau_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
    import rau_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/rau_divider.sv */
// 64-bit restoring divider, one quotient bit per cycle
module rau_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    logic [63:0] r_quot, n_quot;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_dsr;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [64:0] w_trial;
    logic [63:0] w_step_quot, w_step_rem;

    always_comb begin
        w_trial = {r_rem, r_quot[63]} - {1'b0, r_dsr};
        if (!w_trial[64]) begin
            w_step_rem  = w_trial[63:0];
            w_step_quot = {r_quot[62:0], 1'b1};
        end else begin
            w_step_rem  = {r_rem[62:0], r_quot[63]};
            w_step_quot = {r_quot[62:0], 1'b0};
        end
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = w_step_rem;
            n_quot = w_step_quot;
            n_cnt  = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    // result of the last step, valid while o_done is high
    assign o_done = r_busy && (r_cnt == 7'd1);
    assign o_quot = w_step_quot;
    assign o_rem  = w_step_rem;
endmodule

/* src/rational_arithmetic_unit.sv */
// Rational arithmetic unit: takes a_num/a_den, b_num/b_den and a function code, returns one
// fraction in lowest terms with the sign on the numerator (zero as 0/1) and a status. One
// transaction at a time: ready is low while an item is in work and while its result waits.
// After acceptance an item goes through setup: for add, sub, mul and div three products
// on one shared 32x32 multiplier, for the unary functions none. Then come the remainder
// steps of the euclidean gcd (one 64-bit restoring divider, one bit per cycle,
// shared by the gcd and the two final reductions), the divisions of numerator and
// denominator by the gcd, and the check and presentation of the result. A zero numerator
// skips the gcd and the divisions; errors found at entry go straight to the result. A new
// transaction is accepted from the cycle after the result has been taken.
module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rau_req_if.sink   i_req,
    rau_rsp_if.source o_rsp
);
    import rau_pkg::*;

    t_state r_state, n_state;

    logic [31:0] r_an, r_ad, r_bn, r_bd;
    logic        r_sa, r_sb;
    logic [FUNC_W-1:0] r_func;
    logic [63:0] r_t1, r_t2, r_num, r_den, r_x, r_y;
    logic        r_neg;
    logic [63:0] r_g;
    t_rsp        r_rsp;
    logic        r_vld;

    // operand split
    function automatic logic [32:0] split_op(input logic [31:0] v);
        logic [31:0] m;
        logic        s;
        m = v & ((32'hFFFF_FFFF) >> (32 - WIDTH));
        s = m[WIDTH-1];
        if (s) begin
            m = (~m + 32'd1) & ((32'hFFFF_FFFF) >> (32 - WIDTH));
        end
        return {s, m};
    endfunction

    logic [32:0] w_an, w_ad, w_bn, w_bd;
    logic        w_binary;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic        w_s2;
    logic [63:0] w_half;
    logic        w_div_start;
    logic [63:0] w_div_dnd, w_div_dsr;
    logic        w_div_done;
    logic [63:0] w_quot, w_rem;

    assign w_an = split_op(i_req.data.a_num);
    assign w_ad = split_op(i_req.data.a_den);
    assign w_bn = split_op(i_req.data.b_num);
    assign w_bd = split_op(i_req.data.b_den);
    assign w_binary = (i_req.data.func <= FN_DIV);
    assign w_half = 64'd1 << (WIDTH - 1);

    // shared multiplier, one product per cycle
    always_comb begin
        w_ma = r_an;
        w_mb = r_bd;
        case (r_state)
            S_MUL1: begin
                w_ma = r_an;
                w_mb = (r_func == FN_DIV) ? r_bd : ((r_func == FN_MUL) ? r_bn : r_bd);
            end
            S_MUL2: begin
                w_ma = r_bn;
                w_mb = r_ad;
            end
            S_MUL3: begin
                w_ma = r_ad;
                w_mb = r_bd;
            end
            default: begin
                w_ma = r_an;
                w_mb = r_bd;
            end
        endcase
    end
    assign w_prod = {32'd0, w_ma} * {32'd0, w_mb};
    assign w_s2 = (r_func == FN_SUB) ? !r_sb : r_sb;

    rau_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dnd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        w_div_start = 1'b0;
        w_div_dnd   = r_x;
        w_div_dsr   = r_y;
        case (r_state)
            S_COMB: begin
                w_div_start = (r_num != 64'd0);
                w_div_dnd   = r_num;
                w_div_dsr   = r_den;
            end
            S_GCD: begin
                // next remainder step, or num/g once the gcd is found
                w_div_start = w_div_done;
                if (w_rem != 64'd0) begin
                    w_div_dnd = r_y;
                    w_div_dsr = w_rem;
                end else begin
                    w_div_dnd = r_num;
                    w_div_dsr = r_y;
                end
            end
            S_DIVN: begin
                w_div_start = w_div_done;
                w_div_dnd   = r_den;
                w_div_dsr   = r_g;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && !r_vld) begin
                    if (w_ad[31:0] == 32'd0 || (w_binary && w_bd[31:0] == 32'd0)
                        || (i_req.data.func == FN_DIV && w_bn[31:0] == 32'd0)
                        || (i_req.data.func == FN_RECIP && w_an[31:0] == 32'd0)) begin
                        n_state = S_OUT;
                    end else if (w_binary) begin
                        n_state = S_MUL1;
                    end else begin
                        n_state = S_COMB;
                    end
                end
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_COMB;
            S_COMB:  n_state = (r_num == 64'd0) ? S_CHECK : S_GCD;
            S_GCD:   n_state = (w_div_done && w_rem == 64'd0) ? S_DIVN : S_GCD;
            S_DIVN:  n_state = w_div_done ? S_DIVD : S_DIVN;
            S_DIVD:  n_state = w_div_done ? S_CHECK : S_DIVD;
            S_CHECK: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_rsp.valid && o_rsp.ready) begin
                r_vld <= 1'b0;
            end
            if (r_state == S_OUT) begin
                r_vld <= 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    r_func <= i_req.data.func;
                    r_sa   <= w_an[32] != w_ad[32];
                    r_sb   <= w_bn[32] != w_bd[32];
                    r_an   <= w_an[31:0];
                    r_ad   <= w_ad[31:0];
                    r_bn   <= w_bn[31:0];
                    r_bd   <= w_bd[31:0];
                    r_rsp  <= '{res_num: '0, res_den: '0, status: ST_DIV0};
                    // unary ops load num/den directly
                    case (i_req.data.func)
                        FN_NEG: begin
                            r_num <= {32'd0, w_an[31:0]};
                            r_den <= {32'd0, w_ad[31:0]};
                            r_neg <= !(w_an[32] != w_ad[32]);
                        end
                        FN_RECIP: begin
                            r_num <= {32'd0, w_ad[31:0]};
                            r_den <= {32'd0, w_an[31:0]};
                            r_neg <= w_an[32] != w_ad[32];
                        end
                        default: begin
                            r_num <= {32'd0, w_an[31:0]};
                            r_den <= {32'd0, w_ad[31:0]};
                            r_neg <= w_an[32] != w_ad[32];
                        end
                    endcase
                end
            end
            S_MUL1: begin
                r_t1 <= w_prod;
                // div: num = an*bd ; mul: num = an*bn
                if (r_func == FN_DIV) begin
                    r_bd <= r_bn;
                end
            end
            S_MUL2: begin
                r_t2 <= w_prod;
            end
            S_MUL3: begin
                r_den <= w_prod;
                r_neg <= r_sa != r_sb;
                r_num <= r_t1;
                if (r_func == FN_ADD || r_func == FN_SUB) begin
                    if (r_sa == w_s2) begin
                        r_num <= r_t1 + r_t2;
                        r_neg <= r_sa;
                    end else if (r_t1 >= r_t2) begin
                        r_num <= r_t1 - r_t2;
                        r_neg <= r_sa;
                    end else begin
                        r_num <= r_t2 - r_t1;
                        r_neg <= w_s2;
                    end
                end
            end
            S_COMB: begin
                r_x <= r_num;
                r_y <= r_den;
                if (r_num == 64'd0) begin
                    r_den <= 64'd1;
                    r_neg <= 1'b0;
                end
            end
            S_GCD: begin
                if (w_div_done) begin
                    r_x <= r_y;
                    r_y <= w_rem;
                    if (w_rem == 64'd0) begin
                        r_g <= r_y;
                    end
                end
            end
            S_DIVN: begin
                if (w_div_done) begin
                    r_num <= w_quot;
                end
            end
            S_DIVD: begin
                if (w_div_done) begin
                    r_den <= w_quot;
                end
            end
            S_CHECK: begin
                if (r_den > w_half - 64'd1
                    || (r_neg ? (r_num > w_half) : (r_num > w_half - 64'd1))) begin
                    r_rsp <= '{res_num: '0, res_den: '0, status: ST_OVF};
                end else begin
                    r_rsp.res_num <= r_neg ? (32'd0 - r_num[31:0]) : r_num[31:0];
                    r_rsp.res_den <= r_den[DEN_W-1:0];
                    r_rsp.status  <= ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // num/g starts in the last gcd step, den/g starts when num/g is done
    assign o_rsp.valid = r_vld;
    assign o_rsp.data  = r_rsp;
endmodule

/* tb/rational_arithmetic_unit_test.sv */
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;
    import rau_pkg::*;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] MINUS_1 = 32'hffff_ffff;

    logic i_clk;
    logic i_rst_n;
    rau_req_if req_ch ();
    rau_rsp_if rsp_ch ();

    t_rsp fraction_q[$];
    int   fail_count;
    bit   steady;          // no idling on either side

    rational_arithmetic_unit #(.WIDTH(32)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [63:0] magnitude(input logic [31:0] v, output bit sgn);
        sgn = v[31];
        return sgn ? {32'd0, -v} : {32'd0, v};
    endfunction

    function automatic t_rsp predict_fraction(input t_req r);
        logic [63:0] an, ad, bn, bd, num, den, t1, t2, x, y, t;
        logic [63:0] half;
        bit san, sad, sbn, sbd, sa, sb, s2, neg;
        t_rsp o;
        half = 64'd1 << 31;
        o = '0;
        an = magnitude(r.a_num, san);
        ad = magnitude(r.a_den, sad);
        bn = magnitude(r.b_num, sbn);
        bd = magnitude(r.b_den, sbd);
        sa = san != sad;
        sb = sbn != sbd;
        if (ad == 0 || (r.func <= FN_DIV && bd == 0)) begin
            o.status = ST_DIV0;
            return o;
        end
        case (t_func'(r.func))
            FN_ADD, FN_SUB: begin
                t1 = an * bd;
                t2 = bn * ad;
                s2 = (r.func == FN_SUB) ? !sb : sb;
                if (sa == s2) begin
                    num = t1 + t2; neg = sa;
                end else if (t1 >= t2) begin
                    num = t1 - t2; neg = sa;
                end else begin
                    num = t2 - t1; neg = s2;
                end
                den = ad * bd;
            end
            FN_MUL: begin
                num = an * bn; den = ad * bd; neg = sa != sb;
            end
            FN_DIV: begin
                if (bn == 0) begin
                    o.status = ST_DIV0;
                    return o;
                end
                num = an * bd; den = ad * bn; neg = sa != sb;
            end
            FN_NEG: begin
                num = an; den = ad; neg = !sa;
            end
            FN_RECIP: begin
                if (an == 0) begin
                    o.status = ST_DIV0;
                    return o;
                end
                num = ad; den = an; neg = sa;
            end
            default: begin
                num = an; den = ad; neg = sa;
            end
        endcase
        if (num == 0) begin
            den = 1; neg = 0;
        end else begin
            x = num; y = den;
            while (y != 0) begin
                t = x % y; x = y; y = t;
            end
            num = num / x;
            den = den / x;
        end
        if (den > half - 1 || (neg ? (num > half) : (num > half - 1))) begin
            o.status = ST_OVF;
            return o;
        end
        o.res_num = neg ? (32'd0 - num[31:0]) : num[31:0];
        o.res_den = den[30:0];
        o.status  = ST_OK;
        return o;
    endfunction

    task automatic send_item(input t_func f, input logic [31:0] an, input logic [31:0] ad,
                             input logic [31:0] bn, input logic [31:0] bd);
        t_req r;
        r.func = f; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
        while (!steady && $urandom_range(99) < 26) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        fraction_q.push_back(predict_fraction(r));
    endtask

    // response side: random backpressure and checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 26);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (fraction_q.size() == 0) begin
                    $display("%0t: unexpected result num=%h den=%h status=%0d", $time,
                             rsp_ch.data.res_num, rsp_ch.data.res_den, rsp_ch.data.status);
                    fail_count++;
                end else begin
                    t_rsp e;
                    e = fraction_q.pop_front();
                    if (rsp_ch.data.res_num !== e.res_num) begin
                        $display("%0t: res_num expected %h actual %h", $time,
                                 e.res_num, rsp_ch.data.res_num);
                        fail_count++;
                    end
                    if (rsp_ch.data.res_den !== e.res_den) begin
                        $display("%0t: res_den expected %h actual %h", $time,
                                 e.res_den, rsp_ch.data.res_den);
                        fail_count++;
                    end
                    if (rsp_ch.data.status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.status, rsp_ch.data.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return $urandom_range(1000);
            3: return -$urandom_range(1000);
            4: return 32'd1 << $urandom_range(31);
            default: begin
                case ($urandom_range(4))
                    0: return INT_MIN;
                    1: return INT_MAX;
                    2: return MINUS_1;
                    3: return 32'd1;
                    default: return 32'd0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_den();
        logic [31:0] v;
        v = rand_field();
        // keep most denominators nonzero so most items reach the gcd
        if (v == 0 && $urandom_range(9) != 0)
            v = 32'd3;
        return v;
    endfunction

    task automatic test_directed();
        send_item(FN_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_item(FN_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_item(FN_MUL, 32'd6, -32'd4, 32'd2, 32'd9);
        send_item(FN_DIV, -32'd3, 32'd5, 32'd9, -32'd10);
        send_item(FN_NEG, 32'd4, -32'd8, 32'd0, 32'd0);
        send_item(FN_RECIP, -32'd7, 32'd21, 32'd5, 32'd0);
        send_item(FN_NORM, 32'd12, -32'd18, 32'd1, 32'd1);
        send_item(FN_RSVD, -32'd15, -32'd25, 32'd9, 32'd9);
        // zero denominators and zero divisors
        send_item(FN_NORM, 32'd5, 32'd0, 32'd1, 32'd1);
        send_item(FN_ADD, 32'd5, 32'd1, 32'd1, 32'd0);
        send_item(FN_NEG, 32'd5, 32'd2, 32'd1, 32'd0);
        send_item(FN_DIV, 32'd5, 32'd2, 32'd0, 32'd7);
        send_item(FN_RECIP, 32'd0, 32'd2, 32'd1, 32'd1);
        // zero result and extremes, overflow of numerator and denominator
        send_item(FN_MUL, 32'd0, 32'd9, INT_MIN, INT_MAX);
        send_item(FN_NEG, INT_MIN, 32'd1, 32'd0, 32'd0);
        send_item(FN_NORM, INT_MIN, 32'd1, 32'd0, 32'd0);
        send_item(FN_RECIP, 32'd1, INT_MIN, 32'd0, 32'd0);
        send_item(FN_RECIP, MINUS_1, INT_MIN, 32'd0, 32'd0);
        send_item(FN_MUL, INT_MAX, 32'd1, INT_MAX, 32'd1);
        send_item(FN_ADD, INT_MAX, 32'd1, INT_MAX, 32'd1);
        send_item(FN_SUB, INT_MIN, MINUS_1, INT_MAX, INT_MIN);
        send_item(FN_DIV, INT_MIN, INT_MAX, INT_MIN, INT_MAX);
        send_item(FN_ADD, 32'd1, INT_MAX, 32'd1, INT_MAX - 32'd1);
        send_item(FN_DIV, MINUS_1, MINUS_1, MINUS_1, MINUS_1);
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++)
            send_item(t_func'($urandom_range(7)), rand_field(), rand_den(),
                      rand_field(), rand_den());
    endtask

    task automatic test_no_idle(input int n);
        steady = 1'b1;
        test_random(n);
        steady = 1'b0;
    endtask

    initial begin
        int waited;
        fail_count   = 0;
        steady       = 1'b0;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        test_no_idle(150);
        test_random(250);
        req_ch.valid <= 1'b0;
        waited = 0;
        while (fraction_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && fraction_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
src/rau_pkg.sv
src/rau_if.sv
src/rau_divider.sv
src/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
